### rtl/core/ltum_pkg.sv
// Shared types and constants of the lock thread usage monitor.
package ltum_pkg;

	// Payload widths
	localparam int KIND_W   = 4;
	localparam int ID_W     = 32;
	localparam int KEY_W    = KIND_W + ID_W;
	localparam int THR_W    = 16;
	localparam int VERD_W   = 2;
	localparam int TAG_W    = 3;
	localparam int DATA_W   = 56;
	localparam int PAD_W    = DATA_W - KEY_W - THR_W;

	// At most this many reports per flush beat
	localparam int MAX_RES  = 16;
	localparam int CNT_W    = 4;

	// Front queue, depth is a power of two
	localparam int Q_DEPTH  = 2;
	localparam int QPTR_W   = 1;

	// Input event codes
	localparam logic [TAG_W-1:0] KIND_CREATE  = 3'd0;
	localparam logic [TAG_W-1:0] KIND_DESTROY = 3'd1;
	localparam logic [TAG_W-1:0] KIND_LOCK    = 3'd2;
	localparam logic [TAG_W-1:0] KIND_THREAD  = 3'd3;
	localparam logic [TAG_W-1:0] KIND_FLUSH   = 3'd4;

	// Report verdicts
	localparam logic [VERD_W-1:0] VERD_NEVER  = 2'd1;
	localparam logic [VERD_W-1:0] VERD_SINGLE = 2'd2;
	localparam logic [VERD_W-1:0] VERD_FULL   = 2'd3;

	typedef enum logic [1:0] {
		OP_CREATE,
		OP_DESTROY,
		OP_LOCK,
		OP_FLUSH
	} ltum_op_t;

	// Classified event as it travels through the queue
	typedef struct packed {
		ltum_op_t              op;
		logic [KEY_W-1:0]      key;
		logic [THR_W-1:0]      thread;
	} ltum_item_t;

	// One report beat
	typedef struct packed {
		logic [VERD_W-1:0]     verdict;
		logic [KEY_W-1:0]      key;
		logic [THR_W-1:0]      thread;
		logic                  last;
	} ltum_res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACT,
		ST_SCAN,
		ST_EMIT
	} ltum_state_t;

endpackage

### rtl/core/lock_thread_usage_monitor.sv
// Top level of the lock thread usage monitor: front queue and table back end.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/tready    tuser: kind; tdata: object_kind, object_id, thread_id
//  m_*       out  m_tvalid/tready    tuser: verdict; tdata: report_kind, report_id,
//                                    only_thread; tlast: last
//
// In the back end a create, destroy or lock event has its parallel key compare and
// record read when it is taken, then its table update and report in the execute state.
// A flush walks the table one slot a cycle over empty slots; at a live entry it waits
// until the report register takes its report (at most 16 reports). Thread events are
// dropped at the front. Reset empties the table at once. A two-beat queue lets input
// run ahead of the back end; a stalled report holds the back end in place.
module lock_thread_usage_monitor import ltum_pkg::*; #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [DATA_W-1:0]   s_tdata,   // object_kind[3:0], object_id[35:4], thread_id[51:36], zero pad
	input  logic [TAG_W-1:0]    s_tuser,   // kind
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [DATA_W-1:0]   m_tdata,   // report_kind[3:0], report_id[35:4], only_thread[51:36], zero pad
	output logic [VERD_W-1:0]   m_tuser,   // verdict
	output logic                m_tlast
);

	logic        q_valid;
	logic        q_ready;
	ltum_item_t  q_item;
	ltum_res_t   res;

	ltum_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item)
	);

	ltum_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_res    (res)
	);

	// Pack report beat
	assign m_tdata = {{PAD_W{1'b0}}, res.thread, res.key[ID_W-1:0], res.key[KEY_W-1:ID_W]};
	assign m_tuser = res.verdict;
	assign m_tlast = res.last;

endmodule

### rtl/core/ltum_front.sv
// Front end: takes input beats, classifies them and queues the ones that matter.
module ltum_front import ltum_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [DATA_W-1:0]   s_tdata,   // object_kind, object_id, thread_id, pad
	input  logic [TAG_W-1:0]    s_tuser,   // kind
	output logic                q_valid,
	input  logic                q_ready,
	output ltum_item_t          q_item
);

	ltum_item_t         fifo_q [Q_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QPTR_W:0]    count_q;
	ltum_op_t           op;
	logic               keep;
	logic               push;
	logic               pop;

	// Decode event kind; thread events and unused codes are dropped here
	always_comb begin
		keep = 1'b1;
		op   = OP_CREATE;
		case (s_tuser)
			KIND_CREATE:  op = OP_CREATE;
			KIND_DESTROY: op = OP_DESTROY;
			KIND_LOCK:    op = OP_LOCK;
			KIND_FLUSH:   op = OP_FLUSH;
			KIND_THREAD:  keep = 1'b0;
			default:      keep = 1'b0;
		endcase
	end

	assign s_tready = !count_q[QPTR_W];
	assign push     = s_tvalid && s_tready && keep;
	assign pop      = q_valid && q_ready;
	assign q_valid  = count_q != '0;
	assign q_item   = fifo_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q].op     <= op;
			fifo_q[wr_ptr_q].key    <= {s_tdata[KIND_W-1:0], s_tdata[KEY_W-1:KIND_W]};
			fifo_q[wr_ptr_q].thread <= s_tdata[KEY_W+THR_W-1:KEY_W];
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

### rtl/core/ltum_back.sv
// Back end: associative object table, event execution, flush scan and report register.
module ltum_back import ltum_pkg::*; #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_ready,
	input  ltum_item_t          q_item,
	output logic                m_tvalid,
	input  logic                m_tready,
	output ltum_res_t           m_res
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int REC_W = KEY_W + THR_W;

	ltum_state_t             state_q, state_d;

	// Table: valid and lock bits, key cells for compare, record memory
	logic [TABLE_DEPTH-1:0]  valid_q;
	logic [TABLE_DEPTH-1:0]  locked_q;
	logic [KEY_W-1:0]        cam_q [TABLE_DEPTH];
	logic [REC_W-1:0]        rec_mem [TABLE_DEPTH];
	logic [REC_W-1:0]        rd_data_q;
	logic [IDX_W-1:0]        rd_addr;
	logic                    wr_en;
	logic [IDX_W-1:0]        wr_addr;
	logic [REC_W-1:0]        wr_data;
	logic [THR_W-1:0]        rd_thread;

	// Lookup results
	logic [TABLE_DEPTH-1:0]  hit_vec;
	logic [IDX_W-1:0]        hit_idx;
	logic [IDX_W-1:0]        free_idx;
	logic                    hit_any;
	logic                    hit_locked;
	logic                    full;

	// Event being executed
	ltum_item_t              item_q;
	logic                    hit_q;
	logic                    locked_hit_q;
	logic                    full_q;
	logic [IDX_W-1:0]        slot_q;
	logic [IDX_W-1:0]        free_q;

	// Flush scan
	logic [IDX_W-1:0]        scan_ptr_q;
	logic [CNT_W-1:0]        res_cnt_q;
	logic [TABLE_DEPTH-1:0]  above_vec;
	logic                    scan_valid;
	logic                    scan_end;
	logic                    last_res;

	// Control
	logic                    out_valid_q;
	ltum_res_t               out_q;
	logic                    out_free;
	logic                    take;
	logic                    need_emit;
	logic                    act_go;
	logic                    emit_go;
	logic                    out_load;
	ltum_res_t               out_res;

	// Parallel key compare against the queue head, lowest free slot
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			hit_vec[i] = valid_q[i] && (cam_q[i] == q_item.key);
			if (hit_vec[i])
				hit_idx = hit_idx | IDX_W'(i);
		end
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i])
				free_idx = IDX_W'(i);
		end
	end

	assign hit_any    = |hit_vec;
	assign hit_locked = |(hit_vec & locked_q);
	assign full       = &valid_q;
	assign rd_thread  = rd_data_q[THR_W-1:0];

	// Live entries beyond the scan pointer decide the last marker
	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++)
			above_vec[i] = valid_q[i] && (i > int'(scan_ptr_q));
	end

	assign scan_valid = valid_q[scan_ptr_q];
	assign scan_end   = scan_ptr_q == IDX_W'(TABLE_DEPTH - 1);
	assign last_res   = !(|above_vec) || (res_cnt_q == CNT_W'(MAX_RES - 1));
	assign out_free   = !out_valid_q || m_tready;
	assign take       = q_valid && q_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take)
					state_d = (q_item.op == OP_FLUSH) ? ST_SCAN : ST_ACT;
			end
			ST_ACT: begin
				if (act_go)
					state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (scan_valid)
					state_d = ST_EMIT;
				else if (scan_end)
					state_d = ST_IDLE;
			end
			ST_EMIT: begin
				if (emit_go)
					state_d = (last_res || scan_end) ? ST_IDLE : ST_SCAN;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		q_ready   = 1'b0;
		rd_addr   = scan_ptr_q;
		need_emit = 1'b0;
		act_go    = 1'b0;
		emit_go   = 1'b0;
		out_load  = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = slot_q;
		wr_data   = {item_q.key, item_q.thread};
		out_res   = '{verdict: VERD_FULL, key: item_q.key, thread: '0, last: 1'b1};
		case (state_q)
			ST_IDLE: begin
				q_ready = 1'b1;
				rd_addr = hit_idx;
			end
			ST_ACT: begin
				rd_addr = slot_q;
				case (item_q.op)
					OP_CREATE:  need_emit = !hit_q && full_q;
					OP_DESTROY: need_emit = hit_q;
					default:    need_emit = 1'b0;
				endcase
				act_go   = !need_emit || out_free;
				out_load = need_emit && out_free;
				if (item_q.op == OP_DESTROY) begin
					out_res.verdict = locked_hit_q ? VERD_SINGLE : VERD_NEVER;
					out_res.thread  = locked_hit_q ? rd_thread : '0;
				end
				// New entry, or first lock recorded
				if (act_go && item_q.op == OP_CREATE && !hit_q && !full_q) begin
					wr_en   = 1'b1;
					wr_addr = free_q;
					wr_data = {item_q.key, {THR_W{1'b0}}};
				end
				if (act_go && item_q.op == OP_LOCK && hit_q && !locked_hit_q)
					wr_en = 1'b1;
			end
			ST_SCAN: begin
				rd_addr = scan_ptr_q;
			end
			ST_EMIT: begin
				rd_addr  = scan_ptr_q;
				emit_go  = out_free;
				out_load = out_free;
				out_res.verdict = locked_q[scan_ptr_q] ? VERD_SINGLE : VERD_NEVER;
				out_res.key     = rd_data_q[REC_W-1:THR_W];
				out_res.thread  = locked_q[scan_ptr_q] ? rd_thread : '0;
				out_res.last    = last_res;
			end
			default: ;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Record memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			rec_mem[wr_addr] <= wr_data;
		rd_data_q <= rec_mem[rd_addr];
	end

	// Lookup results and event capture
	always_ff @(posedge clk) begin
		if (take) begin
			item_q       <= q_item;
			hit_q        <= hit_any;
			locked_hit_q <= hit_locked;
			full_q       <= full;
			slot_q       <= hit_idx;
			free_q       <= free_idx;
		end
	end

	// Key cells and lock bits
	always_ff @(posedge clk) begin
		if (state_q == ST_ACT && act_go) begin
			if (item_q.op == OP_CREATE && !hit_q && !full_q) begin
				cam_q[free_q]    <= item_q.key;
				locked_q[free_q] <= 1'b0;
			end
			if (item_q.op == OP_LOCK && hit_q && !locked_hit_q)
				locked_q[slot_q] <= 1'b1;
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (state_q == ST_ACT && act_go) begin
			case (item_q.op)
				OP_CREATE: begin
					if (!hit_q && !full_q)
						valid_q[free_q] <= 1'b1;
				end
				OP_DESTROY: begin
					if (hit_q)
						valid_q[slot_q] <= 1'b0;
				end
				OP_LOCK: begin
					// Second thread: shared use, entry dropped silently
					if (hit_q && locked_hit_q && rd_thread != item_q.thread)
						valid_q[slot_q] <= 1'b0;
				end
				default: ;
			endcase
		end else if (state_q == ST_EMIT && emit_go) begin
			valid_q[scan_ptr_q] <= 1'b0;
		end
	end

	// Flush scan pointer and report count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_ptr_q <= '0;
			res_cnt_q  <= '0;
		end else if (take) begin
			scan_ptr_q <= '0;
			res_cnt_q  <= '0;
		end else if (state_q == ST_SCAN && !scan_valid && !scan_end) begin
			scan_ptr_q <= scan_ptr_q + 1'b1;
		end else if (state_q == ST_EMIT && emit_go) begin
			res_cnt_q <= res_cnt_q + 1'b1;
			if (!scan_end)
				scan_ptr_q <= scan_ptr_q + 1'b1;
		end
	end

	// Report register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load)
			out_q <= out_res;
	end

	assign m_tvalid = out_valid_q;
	assign m_res    = out_q;

`ifndef ASSERT_OFF
	// Keys of live entries are unique, so at most one cell matches a queued event
	a_hit_unique: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid |-> $onehot0(hit_vec))
		else $error("more than one table entry matches the key");

	// Reports come only from execution or flush emission
	a_load_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (state_q == ST_ACT || state_q == ST_EMIT))
		else $error("report loaded outside execution or flush");

	// A flush report marked last ends the flush
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && emit_go && last_res) |=> state_q == ST_IDLE)
		else $error("flush went on after its last report");

	// A reported entry is removed from the table
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && emit_go) |=> !valid_q[$past(scan_ptr_q)])
		else $error("flushed entry still live");
`endif

endmodule

### dv/lock_usage_checker.sv
// Checker for the lock thread usage monitor: table predictor and report scoreboard.
`timescale 1ns / 100ps

module lock_usage_checker import ltum_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // object_kind[3:0], object_id[35:4], thread_id[51:36], zero pad
	input  logic [TAG_W-1:0]  s_tuser,   // kind
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [DATA_W-1:0] m_tdata,   // report_kind[3:0], report_id[35:4], only_thread[51:36], zero pad
	input  logic [VERD_W-1:0] m_tuser,   // verdict
	input  logic              m_tlast,
	output int                fail_count,
	output int                pending
);

	// Shadow copy of the object table
	logic             slot_live   [DEPTH];
	logic [KEY_W-1:0] slot_key    [DEPTH];
	logic             slot_locked [DEPTH];
	logic [THR_W-1:0] slot_thread [DEPTH];

	// Reports still owed by the block, oldest first
	ltum_res_t expected_reports[$];
	ltum_res_t seen_report;

	function automatic int lookup_slot(input logic [KEY_W-1:0] key);
		for (int i = 0; i < DEPTH; i++) begin
			if (slot_live[i] && slot_key[i] == key)
				return i;
		end
		return -1;
	endfunction

	task automatic queue_report(input logic [VERD_W-1:0] verdict, input logic [KEY_W-1:0] key,
			input logic [THR_W-1:0] thread, input logic last);
		ltum_res_t r;
		r.verdict = verdict;
		r.key     = key;
		r.thread  = thread;
		r.last    = last;
		expected_reports.push_back(r);
	endtask

	// Apply one accepted event to the shadow table and queue its reports
	task automatic track_event(input logic [TAG_W-1:0] kind, input logic [KEY_W-1:0] key,
			input logic [THR_W-1:0] thread);
		int slot;
		int free_slot;
		int live;
		int n;
		slot = lookup_slot(key);
		case (kind)
			KIND_CREATE: begin
				// duplicates are dropped; lowest free slot wins
				if (slot < 0) begin
					free_slot = -1;
					for (int i = DEPTH - 1; i >= 0; i--)
						if (!slot_live[i])
							free_slot = i;
					if (free_slot < 0) begin
						queue_report(VERD_FULL, key, '0, 1'b1);
					end else begin
						slot_live[free_slot]   = 1'b1;
						slot_key[free_slot]    = key;
						slot_locked[free_slot] = 1'b0;
						slot_thread[free_slot] = '0;
					end
				end
			end
			KIND_DESTROY: begin
				if (slot >= 0) begin
					slot_live[slot] = 1'b0;
					if (slot_locked[slot])
						queue_report(VERD_SINGLE, key, slot_thread[slot], 1'b1);
					else
						queue_report(VERD_NEVER, key, '0, 1'b1);
				end
			end
			KIND_LOCK: begin
				// first locker is recorded, a second thread kills the entry quietly
				if (slot >= 0) begin
					if (!slot_locked[slot]) begin
						slot_locked[slot] = 1'b1;
						slot_thread[slot] = thread;
					end else if (slot_thread[slot] != thread) begin
						slot_live[slot] = 1'b0;
					end
				end
			end
			KIND_FLUSH: begin
				live = 0;
				for (int i = 0; i < DEPTH; i++)
					if (slot_live[i])
						live++;
				if (live > MAX_RES)
					live = MAX_RES;
				n = 0;
				for (int i = 0; i < DEPTH && n < live; i++) begin
					if (slot_live[i]) begin
						slot_live[i] = 1'b0;
						if (slot_locked[i])
							queue_report(VERD_SINGLE, slot_key[i], slot_thread[i], n == live - 1);
						else
							queue_report(VERD_NEVER, slot_key[i], '0, n == live - 1);
						n++;
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_report(input ltum_res_t got);
		ltum_res_t want;
		if (expected_reports.size() == 0) begin
			$display("%0t: unexpected report: verdict %0d kind %0h id %08h thread %04h last %0b",
				$time, got.verdict, got.key[KEY_W-1:ID_W], got.key[ID_W-1:0], got.thread, got.last);
			fail_count++;
		end else begin
			want = expected_reports.pop_front();
			if (got.verdict !== want.verdict || got.key !== want.key ||
					got.thread !== want.thread || got.last !== want.last) begin
				$display("%0t: report mismatch: expected verdict %0d kind %0h id %08h thread %04h last %0b",
					$time, want.verdict, want.key[KEY_W-1:ID_W], want.key[ID_W-1:0],
					want.thread, want.last);
				$display("%0t:                  actual   verdict %0d kind %0h id %08h thread %04h last %0b",
					$time, got.verdict, got.key[KEY_W-1:ID_W], got.key[ID_W-1:0],
					got.thread, got.last);
				fail_count++;
			end
		end
	endtask

	// Reports are checked before the event of the same edge is applied
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				slot_live[i] = 1'b0;
			expected_reports.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen_report.verdict = m_tuser;
				seen_report.key     = {m_tdata[KIND_W-1:0], m_tdata[KEY_W-1:KIND_W]};
				seen_report.thread  = m_tdata[KEY_W+THR_W-1:KEY_W];
				seen_report.last    = m_tlast;
				check_report(seen_report);
			end
			if (s_tvalid && s_tready)
				track_event(s_tuser, {s_tdata[KIND_W-1:0], s_tdata[KEY_W-1:KIND_W]},
					s_tdata[KEY_W+THR_W-1:KEY_W]);
			pending <= expected_reports.size();
		end
	end

endmodule

### dv/tb_lock_thread_usage_monitor.sv
// Top of the lock thread usage monitor testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_lock_thread_usage_monitor;
	import ltum_pkg::*;

	localparam int TABLE_DEPTH = 16;
	localparam int N_ITEMS     = 350;
	localparam int IDLE_PCT    = 13;
	localparam int HOLD_CYC    = 300;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYC   = 40;
	localparam int KEY_POOL    = 20;
	localparam int THR_POOL    = 4;

	// Event codes the block has no meaning for
	localparam logic [TAG_W-1:0] KIND_RSVD5 = 3'd5;
	localparam logic [TAG_W-1:0] KIND_RSVD6 = 3'd6;
	localparam logic [TAG_W-1:0] KIND_RSVD7 = 3'd7;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata  = '0;   // object_kind[3:0], object_id[35:4], thread_id[51:36], zero pad
	logic [TAG_W-1:0]  s_tuser  = '0;   // kind
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;         // report_kind[3:0], report_id[35:4], only_thread[51:36], zero pad
	logic [VERD_W-1:0] m_tuser;         // verdict
	logic              m_tlast;

	int fail_count;
	int pending;
	int idle_cycles = 0;
	int items_sent  = 0;
	bit steady      = 1'b0;
	bit hold_go     = 1'b0;
	bit hold_done   = 1'b0;

	logic [KEY_W-1:0] key_pool [KEY_POOL];
	logic [THR_W-1:0] thr_pool [THR_POOL];

	lock_thread_usage_monitor #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	lock_usage_checker #(
		.DEPTH (TABLE_DEPTH)
	) u_usage_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #2 clk = ~clk;

	function automatic logic [KEY_W-1:0] random_key();
		logic [31:0] hi;
		hi = $urandom;
		return {hi[KIND_W-1:0], 32'($urandom)};
	endfunction

	function automatic logic [THR_W-1:0] random_thread();
		logic [31:0] r;
		r = $urandom;
		return r[THR_W-1:0];
	endfunction

	// Offer one beat, with random gaps in front of it
	task automatic send_event(input logic [TAG_W-1:0] kind, input logic [KEY_W-1:0] key,
			input logic [THR_W-1:0] thread);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {{PAD_W{1'b0}}, thread, key[ID_W-1:0], key[KEY_W-1:ID_W]};
		do @(posedge clk); while (!s_tready);
		if (kind <= KIND_FLUSH && kind != KIND_THREAD)
			items_sent++;
	endtask

	// Stop offering and wait for every owed report
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Report side: random back-pressure plus one long hold-off
	initial begin
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_go && !hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYC) @(posedge clk);
				hold_done = 1'b1;
			end
			m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
			@(posedge clk);
		end
	end

	// Watchdog on beats in either direction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		logic [KEY_W-1:0] k;
		logic [THR_W-1:0] t;
		logic [TAG_W-1:0] kd;
		int roll;
		bit steady_done;
		bit paused;
		steady_done = 1'b0;
		paused      = 1'b0;
		for (int i = 0; i < KEY_POOL; i++)
			key_pool[i] = random_key();
		for (int i = 0; i < THR_POOL; i++)
			thr_pool[i] = random_thread();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: extremes of key and thread, each event kind, corner cases
		send_event(KIND_FLUSH,   '0, '0);            // flush of an empty table
		send_event(KIND_CREATE,  '0, '0);
		send_event(KIND_CREATE,  '1, '0);
		send_event(KIND_CREATE,  '0, '1);            // duplicate create
		send_event(KIND_LOCK,    '0, '0);
		send_event(KIND_LOCK,    '0, '0);            // same thread again
		send_event(KIND_LOCK,    '1, '1);
		send_event(KIND_LOCK,    '1, 16'h5a5a);      // second thread drops the entry
		send_event(KIND_DESTROY, '1, '0);            // now unknown
		send_event(KIND_LOCK,    '1, '1);            // lock of unknown object
		send_event(KIND_DESTROY, '0, '1);            // single thread report
		send_event(KIND_THREAD,  '1, '1);
		send_event(KIND_RSVD5,   '1, '1);
		send_event(KIND_RSVD6,   '1, '1);
		send_event(KIND_RSVD7,   '1, '1);
		send_event(KIND_CREATE,  '1, '0);
		send_event(KIND_DESTROY, '1, '0);            // never locked report

		// Fill the table past full and flush it while reports are held off
		hold_go = 1'b1;
		for (int i = 0; i < TABLE_DEPTH + 2; i++) begin
			k = random_key();
			k[KEY_W-1:ID_W] = i[KIND_W-1:0];
			send_event(KIND_CREATE, k, '0);
			if (i % 3 == 0)
				send_event(KIND_LOCK, k, random_thread());
		end
		send_event(KIND_FLUSH, '0, '0);

		// Random traffic over a small key pool so that entries live and die
		while (items_sent < N_ITEMS) begin
			if (!steady_done && items_sent >= 200) begin
				steady      = 1'b1;
				steady_done = 1'b1;
			end
			if (steady && items_sent >= 270)
				steady = 1'b0;
			if (!paused && items_sent >= 300) begin
				paused = 1'b1;
				wait_drained();
			end
			if ($urandom_range(19) == 0)
				key_pool[$urandom_range(KEY_POOL-1)] = random_key();
			if ($urandom_range(29) == 0)
				thr_pool[$urandom_range(THR_POOL-1)] = random_thread();
			k    = key_pool[$urandom_range(KEY_POOL-1)];
			t    = thr_pool[$urandom_range(THR_POOL-1)];
			roll = $urandom_range(99);
			if (roll < 34) begin
				send_event(KIND_CREATE, k, t);
			end else if (roll < 62) begin
				send_event(KIND_LOCK, k, t);
			end else if (roll < 82) begin
				send_event(KIND_DESTROY, k, t);
			end else if (roll < 86) begin
				send_event(KIND_FLUSH, k, t);
			end else if (roll < 91) begin
				case ($urandom_range(3))
					0:       kd = KIND_THREAD;
					1:       kd = KIND_RSVD5;
					2:       kd = KIND_RSVD6;
					default: kd = KIND_RSVD7;
				endcase
				send_event(kd, random_key(), random_thread());
			end else begin
				// noise: fresh keys that mostly miss the table
				case ($urandom_range(2))
					0:       kd = KIND_CREATE;
					1:       kd = KIND_DESTROY;
					default: kd = KIND_LOCK;
				endcase
				send_event(kd, random_key(), random_thread());
			end
		end

		wait_drained();
		repeat (DRAIN_CYC) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
